@@ hdl/pwmt_pkg.sv @@
// ============================================================================
// pwmt_pkg
// Shared constants, codes and types of the PWM compare timer.
// ============================================================================
package pwmt_pkg;

    localparam int CHANNEL_COUNT = 4;
    localparam int COUNTER_WIDTH = 16;

    // Compare values reach reload + 1, so they need one bit more than the counter.
    localparam int CMP_W        = COUNTER_WIDTH + 1;
    localparam int VALUE_W      = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int LEVELS_W     = 4;
    localparam int CH_W         = 2;
    localparam int OP_W         = 3;
    localparam int WIDE_W       = (CMP_W > VALUE_W) ? CMP_W : VALUE_W;

    localparam int PERCENT_FULL = 100;
    localparam int DUTY_W       = 7;
    localparam int PROD_W       = DUTY_W + CMP_W;
    // Division by one hundred is done as a multiply by a rounded-up reciprocal.
    localparam int RECIP_SHIFT  = PROD_W + DUTY_W;
    localparam int RECIP_W      = RECIP_SHIFT - 6;
    localparam int MUL_W        = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DUTY_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PERCENT_FULL) - 64'd1) / 64'(PERCENT_FULL));

    localparam logic [COUNTER_WIDTH-1:0] RELOAD_RESET = COUNTER_WIDTH'(999);

    localparam int OUT_W        = LEVELS_W + COUNTER_WIDTH + 2;
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;
    localparam int IN_TUSER_W   = OP_W + CH_W;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_DUTY  = 3'd1,
        OP_RAW   = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4,
        OP_ACK   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        MODE_FROZEN     = 3'd0,
        MODE_SET        = 3'd1,
        MODE_CLEAR      = 3'd2,
        MODE_TOGGLE     = 3'd3,
        MODE_FORCE_LOW  = 3'd4,
        MODE_FORCE_HIGH = 3'd5,
        MODE_PWM1       = 3'd6,
        MODE_PWM2       = 3'd7
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRESCALER   = 3'd0,
        CFG_RELOAD      = 3'd1,
        CFG_MODE_FIRST  = 3'd2,
        CFG_MODE_SECOND = 3'd3,
        CFG_MODE_THIRD  = 3'd4,
        CFG_MODE_FOURTH = 3'd5,
        CFG_OUT_EN      = 3'd6,
        CFG_IRQ_EN      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [COUNTER_WIDTH-1:0]            prescaler;
        logic [COUNTER_WIDTH-1:0]            reload;
        mode_t [CHANNEL_COUNT-1:0]           mode;
        logic [LEVELS_W-1:0]                 out_en;
        logic                                irq_en;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [CH_W-1:0]   ch;
        logic [CMP_W-1:0]  cmp;
    } cmd_t;

    typedef struct packed {
        logic                      irq;
        logic                      pending;
        logic [COUNTER_WIDTH-1:0]  count;
        logic [LEVELS_W-1:0]       levels;
    } result_t;

    function automatic logic is_pwm(input mode_t m);
        return (m == MODE_PWM1) || (m == MODE_PWM2);
    endfunction

endpackage

@@ hdl/pwm_compare_timer.sv @@
// A request passes the front-end input, product and command registers, then the result register.
// Throughput: one request per cycle while the output takes results; the state update is
// combinational, and the duty scaling and division sit in front-end stages one and two.
// Reset: rst_n clears the timer, compare values, levels and flags, and loads the
// register defaults (reload 999, all else zero); no clearing pass is needed.
// ============================================================================
// pwm_compare_timer
// Four-channel up-counting timer with prescaler, auto-reload and compare outputs.
// ============================================================================
module pwm_compare_timer
    import pwmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_W-1:0]     s_axis_tdata,    // [15:0] value
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,    // [2:0] opcode, [4:3] channel

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,    // [3:0] channel_levels, [19:4] count,
                                                    // [20] update_pending, [21] interrupt

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    result_t result;

    pwmt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwmt_cmp_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser[OP_W-1:0]),
        .in_ch     (s_axis_tuser[OP_W +: CH_W]),
        .in_value  (s_axis_tdata),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_cmd   (cmd)
    );

    pwmt_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (cmd_valid),
        .in_ready   (cmd_ready),
        .in_cmd     (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

@@ hdl/pwmt_cfg.sv @@
// ============================================================================
// pwmt_cfg
// Configuration register file, written through the register request channel.
// ============================================================================
module pwmt_cfg
    import pwmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t                   cfg_reg;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] mode_slot;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign mode_slot = cfg_index - CFG_MODE_FIRST;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescaler <= '0;
            cfg_reg.reload    <= RELOAD_RESET;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                cfg_reg.mode[i] <= MODE_FROZEN;
            end
            cfg_reg.out_en    <= '0;
            cfg_reg.irq_en    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PRESCALER:
                begin
                    cfg_reg.prescaler <= COUNTER_WIDTH'(cfg_data);
                end
                CFG_RELOAD:
                begin
                    cfg_reg.reload <= COUNTER_WIDTH'(cfg_data);
                end
                CFG_MODE_FIRST, CFG_MODE_SECOND, CFG_MODE_THIRD, CFG_MODE_FOURTH:
                begin
                    // Mode registers of channels that are not built are dropped.
                    for (int i = 0; i < CHANNEL_COUNT; i++)
                    begin
                        if (mode_slot == CFG_INDEX_W'(i))
                        begin
                            cfg_reg.mode[i] <= mode_t'(cfg_data[2:0]);
                        end
                    end
                end
                CFG_OUT_EN:
                begin
                    cfg_reg.out_en <= cfg_data[LEVELS_W-1:0];
                end
                CFG_IRQ_EN:
                begin
                    cfg_reg.irq_en <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ hdl/pwmt_cmp_calc.sv @@
// ============================================================================
// pwmt_cmp_calc
// Three-stage front end that turns a duty or raw request into a compare value.
// ============================================================================
module pwmt_cmp_calc
    import pwmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    in_op,
    input  logic [CH_W-1:0]    in_ch,
    input  logic [VALUE_W-1:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output cmd_t               out_cmd
);

    logic               v1_reg, v2_reg, v3_reg;
    logic               rdy1, rdy2, rdy3;

    op_t                op1_reg, op2_reg;
    logic [CH_W-1:0]    ch1_reg, ch2_reg;
    logic [VALUE_W-1:0] val1_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [CMP_W-1:0]   raw2_reg;
    cmd_t               cmd3_reg;

    logic [CMP_W-1:0]   top;
    logic [DUTY_W-1:0]  duty;
    logic [PROD_W-1:0]  prod_next;
    logic [CMP_W-1:0]   raw_next;
    logic [MUL_W-1:0]   quot_full;
    logic [CMP_W-1:0]   quot;
    cmd_t               cmd_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage one: clamp and scale by reload + 1.
    always_comb
    begin
        top       = CMP_W'(cfg.reload) + CMP_W'(1);
        duty      = (val1_reg > VALUE_W'(PERCENT_FULL)) ? DUTY_W'(PERCENT_FULL)
                                                        : val1_reg[DUTY_W-1:0];
        prod_next = PROD_W'(duty) * PROD_W'(top);
        raw_next  = (WIDE_W'(val1_reg) > WIDE_W'(top)) ? top : CMP_W'(val1_reg);
    end

    // Stage two: divide the product by one hundred.
    always_comb
    begin
        quot_full    = MUL_W'(prod2_reg) * MUL_W'(DUTY_RECIP);
        quot         = quot_full[RECIP_SHIFT +: CMP_W];
        cmd_next.op  = op2_reg;
        cmd_next.ch  = ch2_reg;
        cmd_next.cmp = (op2_reg == OP_DUTY) ? quot : raw2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            op1_reg  <= op_t'(in_op);
            ch1_reg  <= in_ch;
            val1_reg <= in_value;
        end
        if (rdy2 && v1_reg)
        begin
            op2_reg   <= op1_reg;
            ch2_reg   <= ch1_reg;
            prod2_reg <= prod_next;
            raw2_reg  <= raw_next;
        end
        if (rdy3 && v2_reg)
        begin
            cmd3_reg <= cmd_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_cmd   = cmd3_reg;

endmodule

@@ hdl/pwmt_core.sv @@
// ============================================================================
// pwmt_core
// Timer state update, channel level evaluation and the result register.
// ============================================================================
module pwmt_core
    import pwmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  cmd_t    in_cmd,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic [COUNTER_WIDTH-1:0] count_reg, count_next;
    logic [COUNTER_WIDTH-1:0] pres_reg, pres_next;
    logic [CMP_W-1:0]         active_reg [CHANNEL_COUNT];
    logic [CMP_W-1:0]         active_next [CHANNEL_COUNT];
    logic [CMP_W-1:0]         pending_reg [CHANNEL_COUNT];
    logic [CMP_W-1:0]         pending_next [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] level_reg, level_next;
    logic                     running_reg, running_next;
    logic                     flag_reg, flag_next;
    logic                     advanced;
    logic                     match;
    logic                     below;
    logic                     accept;

    logic                     ov_reg;
    result_t                  res_reg;
    result_t                  res_next;

    assign in_ready = !ov_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        count_next   = count_reg;
        pres_next    = pres_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        level_next   = level_reg;
        running_next = running_reg;
        flag_next    = flag_reg;
        advanced     = 1'b0;
        match        = 1'b0;
        below        = 1'b0;

        unique case (in_cmd.op)
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (pres_reg < cfg.prescaler)
                    begin
                        pres_next = pres_reg + COUNTER_WIDTH'(1);
                    end
                    else
                    begin
                        pres_next = '0;
                        advanced  = 1'b1;
                        // A count above reload also wraps, as after reload was lowered.
                        if (count_reg >= cfg.reload)
                        begin
                            count_next = '0;
                            flag_next  = 1'b1;
                            for (int i = 0; i < CHANNEL_COUNT; i++)
                            begin
                                if (is_pwm(cfg.mode[i]))
                                begin
                                    active_next[i] = pending_reg[i];
                                end
                            end
                        end
                        else
                        begin
                            count_next = count_reg + COUNTER_WIDTH'(1);
                        end
                    end
                end
            end
            OP_DUTY, OP_RAW:
            begin
                // PWM channels take the new value only at the next update.
                for (int i = 0; i < CHANNEL_COUNT; i++)
                begin
                    if (in_cmd.ch == CH_W'(i))
                    begin
                        pending_next[i] = in_cmd.cmp;
                        if (!is_pwm(cfg.mode[i]))
                        begin
                            active_next[i] = in_cmd.cmp;
                        end
                    end
                end
            end
            OP_START:
            begin
                running_next = 1'b1;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
            end
            OP_ACK:
            begin
                flag_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            match = advanced && (CMP_W'(count_next) == active_next[i]);
            below = CMP_W'(count_next) < active_next[i];
            unique case (cfg.mode[i])
                MODE_FROZEN:
                begin
                end
                MODE_SET:
                begin
                    if (match)
                    begin
                        level_next[i] = 1'b1;
                    end
                end
                MODE_CLEAR:
                begin
                    if (match)
                    begin
                        level_next[i] = 1'b0;
                    end
                end
                MODE_TOGGLE:
                begin
                    if (match)
                    begin
                        level_next[i] = !level_reg[i];
                    end
                end
                MODE_FORCE_LOW:
                begin
                    level_next[i] = 1'b0;
                end
                MODE_FORCE_HIGH:
                begin
                    level_next[i] = 1'b1;
                end
                MODE_PWM1:
                begin
                    level_next[i] = below;
                end
                MODE_PWM2:
                begin
                    level_next[i] = !below;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.levels = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            res_next.levels[i] = level_next[i] && cfg.out_en[i];
        end
        res_next.count   = count_next;
        res_next.pending = flag_next;
        res_next.irq     = flag_next && cfg.irq_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pres_reg    <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                active_reg[i]  <= '0;
                pending_reg[i] <= '0;
            end
            level_reg   <= '0;
            running_reg <= 1'b0;
            flag_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg   <= count_next;
                pres_reg    <= pres_next;
                active_reg  <= active_next;
                pending_reg <= pending_next;
                level_reg   <= level_next;
                running_reg <= running_next;
                flag_reg    <= flag_next;
            end
            if (in_ready)
            begin
                ov_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_result = res_reg;

endmodule

@@ hdl/pwmt_checker.sv @@
// ============================================================================
// pwmt_checker
// Port-level checks of the PWM compare timer, bound to the top level.
// ============================================================================
module pwmt_checker
    import pwmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // The interrupt bit can only be set together with the update flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[OUT_W-1] || m_axis_tdata[OUT_W-2]))
        else $error("interrupt without update flag");

    // The input side only stalls when a result is held at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // A result that is not taken stays and holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // The padding bits above the result fields are always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_W] == '0))
        else $error("result padding bits set");

endmodule

bind pwm_compare_timer pwmt_checker u_pwmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
